// ===== design/lsd_pkg.sv =====
// Shared constants for the decimal LSD radix sorter.
// No dependencies. Used by the divide-by-ten unit, the top level and the testbench.
package lsd_pkg;

    localparam int VAL_W         = 31;
    localparam int RAM_W         = 2 * VAL_W;
    localparam int DIGIT_W       = 4;
    localparam int NUM_DIGITS    = 10;
    localparam int MAX_ITEMS_DEF = 64;

    // A 31-bit q times RECIP, shifted right by Q_SHIFT, is q / 10.
    localparam logic [31:0] RECIP   = 32'hCCCC_CCCD;
    localparam int          Q_SHIFT = 35;
    localparam int          PROD_W  = VAL_W + 32;
    localparam int          QUOT_W  = PROD_W - Q_SHIFT;

    localparam logic [DIGIT_W-1:0] PASS_LIMIT = 4'd10;
    localparam logic [DIGIT_W-1:0] LAST_DIGIT = 4'd9;

endpackage

// ===== design/lsd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lsd_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [W-1:0]             wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [W-1:0]             rdata
);

    logic [W-1:0] mem_reg [DEPTH];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/lsd_div10.sv =====
// Shared divide-by-ten unit: reciprocal multiply, one register, then remainder.
// Depends on lsd_pkg.
module lsd_div10 (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_v,
    input  logic [lsd_pkg::VAL_W-1:0]        q,
    input  logic [lsd_pkg::VAL_W-1:0]        tag,
    output logic                             out_v,
    output logic [lsd_pkg::QUOT_W-1:0]       quot,
    output logic [lsd_pkg::DIGIT_W-1:0]      digit,
    output logic [lsd_pkg::VAL_W-1:0]        tag_out
);

    logic [lsd_pkg::PROD_W-1:0] prod_next;
    logic [lsd_pkg::PROD_W-1:0] prod_reg;
    logic [lsd_pkg::VAL_W-1:0]  q_reg;
    logic [lsd_pkg::VAL_W-1:0]  tag_reg;
    logic                       v_reg;
    logic [lsd_pkg::VAL_W-1:0]  tenq;
    logic [lsd_pkg::VAL_W-1:0]  rem;

    assign prod_next = lsd_pkg::PROD_W'(q) * lsd_pkg::PROD_W'(lsd_pkg::RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= in_v;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        q_reg    <= q;
        tag_reg  <= tag;
    end

    assign quot    = prod_reg[lsd_pkg::PROD_W-1:lsd_pkg::Q_SHIFT];
    assign tenq    = lsd_pkg::VAL_W'({quot, 3'b000}) + lsd_pkg::VAL_W'({quot, 1'b0});
    assign rem     = q_reg - tenq;
    assign digit   = rem[lsd_pkg::DIGIT_W-1:0];
    assign out_v   = v_reg;
    assign tag_out = tag_reg;

endmodule

// ===== design/lsd_decimal_radix_sort.sv =====
// Decimal LSD radix sorter. Loading takes one cycle per beat; the last beat starts the sort.
// Each pass runs the stored items through the shared divide-by-ten unit; passes = decimal
// digits of the maximum, at most ten. Results then leave one beat at a time. Input is stalled
// from the last beat until the final result is taken. Reset clears all control state; RAM
// contents are left undefined.
module lsd_decimal_radix_sort #(
    parameter int MAX_ITEMS = lsd_pkg::MAX_ITEMS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [lsd_pkg::VAL_W-1:0]  value,
    input  logic                       last_item,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [lsd_pkg::VAL_W-1:0]  sorted_value,
    output logic                       last_result,
    output logic                       dropped
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_CHECK    = 10'b00_0000_0010,
        S_HIST     = 10'b00_0000_0100,
        S_PREFIX   = 10'b00_0000_1000,
        S_SCAT     = 10'b00_0001_0000,
        S_DIVMAX   = 10'b00_0010_0000,
        S_DIVWAIT  = 10'b00_0100_0000,
        S_OUT_RD   = 10'b00_1000_0000,
        S_OUT_LD   = 10'b01_0000_0000,
        S_OUT_WAIT = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0]                    item_cnt_reg, item_cnt_next;
    logic [lsd_pkg::VAL_W-1:0]        max_reg, max_next;
    logic                             ovf_reg, ovf_next;
    logic [CW-1:0]                    idx_reg, idx_next;
    logic [lsd_pkg::DIGIT_W-1:0]      k_reg, k_next;
    logic [lsd_pkg::DIGIT_W-1:0]      pass_reg, pass_next;
    logic                             src_reg, src_next;
    logic                             rd_v_reg, rd_v_next;
    logic                             out_valid_reg, out_valid_next;
    logic [CW-1:0]                    cnt_reg [lsd_pkg::NUM_DIGITS];
    logic [CW-1:0]                    cnt_next [lsd_pkg::NUM_DIGITS];

    logic [lsd_pkg::VAL_W-1:0]        sorted_value_reg;
    logic                             last_result_reg;
    logic                             dropped_reg;
    logic                             load_out;

    logic                             we_a, we_b;
    logic [AW-1:0]                    wa_a, wa_b, rd_addr;
    logic [lsd_pkg::RAM_W-1:0]        wd_a, wd_b, rd_a, rd_b, rd_data;
    logic [lsd_pkg::VAL_W-1:0]        rd_val, rd_q;

    logic                             u_v;
    logic [lsd_pkg::VAL_W-1:0]        u_q_in;
    logic [lsd_pkg::QUOT_W-1:0]       u_quot;
    logic [lsd_pkg::DIGIT_W-1:0]      u_digit;
    logic [lsd_pkg::VAL_W-1:0]        u_tag;

    logic [CW-1:0]                    slot;
    logic [lsd_pkg::RAM_W-1:0]        scat_data;
    logic [CW-1:0]                    idx_dec, idx_inc, n_last;

    lsd_ram #(.W(lsd_pkg::RAM_W), .DEPTH(MAX_ITEMS)) u_ram_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (wa_a),
        .wdata (wd_a),
        .raddr (rd_addr),
        .rdata (rd_a)
    );

    lsd_ram #(.W(lsd_pkg::RAM_W), .DEPTH(MAX_ITEMS)) u_ram_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (wa_b),
        .wdata (wd_b),
        .raddr (rd_addr),
        .rdata (rd_b)
    );

    assign rd_data = src_reg ? rd_b : rd_a;
    assign rd_val  = rd_data[lsd_pkg::RAM_W-1:lsd_pkg::VAL_W];
    assign rd_q    = rd_data[lsd_pkg::VAL_W-1:0];
    assign u_q_in  = (state_reg == S_DIVMAX) ? max_reg : rd_q;

    lsd_div10 u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_v    (rd_v_reg),
        .q       (u_q_in),
        .tag     (rd_val),
        .out_v   (u_v),
        .quot    (u_quot),
        .digit   (u_digit),
        .tag_out (u_tag)
    );

    assign slot      = cnt_reg[u_digit] - 1'b1;
    assign scat_data = {u_tag, lsd_pkg::VAL_W'(u_quot)};
    assign idx_dec   = idx_reg - 1'b1;
    assign idx_inc   = idx_reg + 1'b1;
    assign n_last    = item_cnt_reg - 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        item_cnt_next  = item_cnt_reg;
        max_next       = max_reg;
        ovf_next       = ovf_reg;
        idx_next       = idx_reg;
        k_next         = k_reg;
        pass_next      = pass_reg;
        src_next       = src_reg;
        rd_v_next      = 1'b0;
        out_valid_next = out_valid_reg;
        cnt_next       = cnt_reg;
        load_out       = 1'b0;
        rd_addr        = idx_reg[AW-1:0];
        we_a           = 1'b0;
        we_b           = 1'b0;
        wa_a           = slot[AW-1:0];
        wa_b           = slot[AW-1:0];
        wd_a           = scat_data;
        wd_b           = scat_data;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (item_cnt_reg < MAX_CNT)
                    begin
                        we_a          = 1'b1;
                        wa_a          = item_cnt_reg[AW-1:0];
                        wd_a          = {value, value};
                        item_cnt_next = item_cnt_reg + 1'b1;
                        if (value > max_reg)
                        begin
                            max_next = value;
                        end
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_item)
                    begin
                        pass_next  = '0;
                        src_next   = 1'b0;
                        state_next = S_CHECK;
                    end
                end
            end

            S_CHECK:
            begin
                idx_next = '0;
                if (max_reg == '0 || pass_reg == lsd_pkg::PASS_LIMIT)
                begin
                    state_next = S_OUT_RD;
                end
                else
                begin
                    for (int i = 0; i < lsd_pkg::NUM_DIGITS; i++)
                    begin
                        cnt_next[i] = '0;
                    end
                    state_next = S_HIST;
                end
            end

            S_HIST:
            begin
                if (u_v)
                begin
                    cnt_next[u_digit] = cnt_reg[u_digit] + 1'b1;
                end
                if (idx_reg < item_cnt_reg)
                begin
                    rd_v_next = 1'b1;
                    idx_next  = idx_inc;
                end
                else if (!rd_v_reg && !u_v)
                begin
                    k_next     = 4'd1;
                    state_next = S_PREFIX;
                end
            end

            S_PREFIX:
            begin
                cnt_next[k_reg] = cnt_reg[k_reg] + cnt_reg[k_reg - 1'b1];
                if (k_reg == lsd_pkg::LAST_DIGIT)
                begin
                    idx_next   = item_cnt_reg;
                    state_next = S_SCAT;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end

            S_SCAT:
            begin
                // Backward walk keeps equal digits in arrival order.
                if (u_v)
                begin
                    cnt_next[u_digit] = slot;
                    we_a = src_reg;
                    we_b = !src_reg;
                end
                if (idx_reg != '0)
                begin
                    rd_addr   = idx_dec[AW-1:0];
                    rd_v_next = 1'b1;
                    idx_next  = idx_dec;
                end
                else if (!rd_v_reg && !u_v)
                begin
                    state_next = S_DIVMAX;
                end
            end

            S_DIVMAX:
            begin
                state_next = S_DIVWAIT;
            end

            S_DIVWAIT:
            begin
                max_next   = lsd_pkg::VAL_W'(u_quot);
                pass_next  = pass_reg + 1'b1;
                src_next   = !src_reg;
                state_next = S_CHECK;
            end

            S_OUT_RD:
            begin
                state_next = S_OUT_LD;
            end

            S_OUT_LD:
            begin
                load_out       = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_OUT_WAIT;
            end

            S_OUT_WAIT:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    if (idx_reg == n_last)
                    begin
                        item_cnt_next = '0;
                        max_next      = '0;
                        ovf_next      = 1'b0;
                        for (int i = 0; i < lsd_pkg::NUM_DIGITS; i++)
                        begin
                            cnt_next[i] = '0;
                        end
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_inc;
                        rd_addr    = idx_inc[AW-1:0];
                        state_next = S_OUT_LD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            item_cnt_reg  <= '0;
            max_reg       <= '0;
            ovf_reg       <= 1'b0;
            idx_reg       <= '0;
            k_reg         <= '0;
            pass_reg      <= '0;
            src_reg       <= 1'b0;
            rd_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < lsd_pkg::NUM_DIGITS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            item_cnt_reg  <= item_cnt_next;
            max_reg       <= max_next;
            ovf_reg       <= ovf_next;
            idx_reg       <= idx_next;
            k_reg         <= k_next;
            pass_reg      <= pass_next;
            src_reg       <= src_next;
            rd_v_reg      <= rd_v_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            sorted_value_reg <= rd_val;
            last_result_reg  <= (idx_reg == n_last);
            dropped_reg      <= ovf_reg;
        end
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign sorted_value = sorted_value_reg;
    assign last_result  = last_result_reg;
    assign dropped      = dropped_reg;

endmodule

// ===== design/lsd_checker.sv =====
// Port-level checks for the decimal LSD radix sorter, bound to the top level.
// No package dependencies.
module lsd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [30:0] value,
    input logic        last_item,
    input logic        out_valid,
    input logic        out_stall,
    input logic [30:0] sorted_value,
    input logic        last_result,
    input logic        dropped
);

    // A stalled result beat holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sorted_value)
            && $stable(last_result) && $stable(dropped))
        else $error("stalled result changed");

    // The last input beat starts the sort, so input must stall next.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_item |=> in_stall)
        else $error("input not stalled after last beat");

    // No input is taken while results are being delivered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open during emission");

    // After the final result is taken the block returns to loading.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last_result |=> !out_valid && !in_stall)
        else $error("block did not return to loading");

endmodule

bind lsd_decimal_radix_sort lsd_checker u_lsd_checker (.*);

// ===== test/lsd_decimal_radix_sort_tb.sv =====
`timescale 1ns / 100ps
// Testbench for the decimal LSD radix sorter: sets of values are sent, sorted results are
// predicted by a stable digit-by-digit sort in the testbench and checked beat by beat.
// Depends on lsd_pkg and lsd_decimal_radix_sort.
module lsd_decimal_radix_sort_tb;

    localparam int VAL_W = lsd_pkg::VAL_W;
    localparam int CAP   = lsd_pkg::MAX_ITEMS_DEF;

    typedef struct packed {
        logic [VAL_W-1:0] val;
        logic             last;
        logic             drop;
    } sorted_beat_t;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic [VAL_W-1:0] value;
    logic             last_item;
    logic             out_valid;
    logic             out_stall;
    logic [VAL_W-1:0] sorted_value;
    logic             last_result;
    logic             dropped;

    // Predictor state.
    logic [VAL_W-1:0] set_vals[$];
    logic [VAL_W-1:0] set_max;
    logic             set_overflow;
    sorted_beat_t     sorted_expected[$];

    int  error_count;
    bit  hold_off;
    bit  calm;

    lsd_decimal_radix_sort uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .value        (value),
        .last_item    (last_item),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sorted_value (sorted_value),
        .last_result  (last_result),
        .dropped      (dropped)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #200ms;
        $display("lsd_decimal_radix_sort_tb: done, errors");
        $finish;
    end

    task automatic report(input string what, input logic [VAL_W-1:0] got,
                          input logic [VAL_W-1:0] want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Stable LSD sort in base ten, one counting pass per digit of the maximum.
    task automatic predict_sorted_set();
        logic [VAL_W-1:0] a[$];
        logic [VAL_W-1:0] b[$];
        longint unsigned  weight;
        int               passes;
        int               n;
        sorted_beat_t     beat;
        a = set_vals;
        n = a.size();
        weight = 1;
        passes = 0;
        while (passes < 10 && (longint'(set_max) / weight) > 0)
        begin
            b = {};
            for (int d = 0; d < 10; d++)
                foreach (a[i])
                    if ((longint'(a[i]) / weight) % 10 == d)
                        b.push_back(a[i]);
            a = b;
            weight *= 10;
            passes++;
        end
        for (int i = 0; i < n; i++)
        begin
            beat.val  = a[i];
            beat.last = (i == n - 1);
            beat.drop = set_overflow;
            sorted_expected.push_back(beat);
        end
        set_vals = {};
        set_max = '0;
        set_overflow = 1'b0;
    endtask

    // Valid stays up after a beat is taken unless a gap follows, so that no edge
    // sees both a drop and a raise of in_valid.
    task automatic send_beat(input logic [VAL_W-1:0] v, input logic lst);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 18);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        repeat (gap)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        value     <= v;
        last_item <= lst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (set_vals.size() < CAP)
        begin
            set_vals.push_back(v);
            if (v > set_max)
                set_max = v;
        end
        else
            set_overflow = 1'b1;
        if (lst)
            predict_sorted_set();
    endtask

    // Receiver: random stalls, plus a long hold-off while hold_off is set.
    initial
    begin
        int wait_cycles;
        out_stall <= 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
                out_stall <= 1'b1;
            else if (out_stall)
                out_stall <= 1'b0;
            else if (out_valid)
            begin
                wait_cycles = calm ? 0 : $urandom_range(0, 18);
                if ($urandom_range(0, 3) == 0)
                    wait_cycles = 0;
                if (wait_cycles > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (wait_cycles - 1)
                        @(posedge clk);
                end
            end
        end
    end

    // Checker for each result beat.
    always @(posedge clk)
    begin
        sorted_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (sorted_expected.size() == 0)
            begin
                report("unexpected beat", sorted_value, '0);
            end
            else
            begin
                want = sorted_expected.pop_front();
                if (sorted_value !== want.val)
                    report("sorted_value", sorted_value, want.val);
                if (last_result !== want.last)
                    report("last_result", last_result, want.last);
                if (dropped !== want.drop)
                    report("dropped", dropped, want.drop);
            end
        end
    end

    function automatic logic [VAL_W-1:0] random_value();
        case ($urandom_range(0, 4))
            0: return VAL_W'($urandom_range(0, 9));
            1: return VAL_W'($urandom_range(0, 999));
            2: return VAL_W'($urandom_range(0, 99999));
            3: return VAL_W'($urandom);
            default: return (VAL_W'(1) << $urandom_range(0, VAL_W - 1))
                            | VAL_W'($urandom_range(0, 1));
        endcase
    endfunction

    task automatic send_set(input int n);
        for (int i = 0; i < n; i++)
            send_beat(random_value(), i == n - 1);
    endtask

    task automatic test_directed_extremes();
        send_beat('0, 1'b1);
        send_beat('0, 1'b0);
        send_beat('0, 1'b0);
        send_beat('0, 1'b1);
        send_beat(VAL_W'(7), 1'b0);
        send_beat(VAL_W'(3), 1'b0);
        send_beat(VAL_W'(7), 1'b1);
        send_beat({VAL_W{1'b1}}, 1'b0);
        send_beat('0, 1'b0);
        send_beat(VAL_W'(1000000000), 1'b0);
        send_beat(VAL_W'(999999999), 1'b0);
        send_beat(VAL_W'(10), 1'b0);
        send_beat(VAL_W'(1), 1'b0);
        send_beat({VAL_W{1'b1}}, 1'b0);
        send_beat(VAL_W'(21), 1'b0);
        send_beat(VAL_W'(12), 1'b1);
    endtask

    // A full store followed by extra beats; the extras are dropped and flagged. Then an exactly full set.
    task automatic test_store_full();
        for (int i = 0; i < CAP + 3; i++)
            send_beat(random_value(), i == CAP + 2);
        for (int i = 0; i < CAP; i++)
            send_beat(VAL_W'($urandom_range(0, 99)), i == CAP - 1);
    endtask

    // Receiver holds off while sets keep arriving, so the input stalls.
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (3000)
                    @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                send_set(5);
                send_set(4);
            end
        join
    endtask

    task automatic test_random_sets();
        int sent;
        int n;
        sent = 0;
        while (sent < 200)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(CAP - 2, CAP + 2)
                                             : $urandom_range(1, 12);
            calm = ($urandom_range(0, 4) == 0);
            send_set(n);
            sent += n;
        end
        calm = 1'b0;
    endtask

    initial
    begin
        int guard;
        error_count  = 0;
        hold_off     = 1'b0;
        calm         = 1'b0;
        set_max      = '0;
        set_overflow = 1'b0;
        rst_n        = 1'b0;
        in_valid     <= 1'b0;
        value        <= '0;
        last_item    <= 1'b0;
        repeat (2)
            @(posedge clk);
        rst_n = 1'b1;
        @(posedge clk);
        test_directed_extremes();
        test_store_full();
        test_backpressure();
        test_random_sets();
        in_valid <= 1'b0;
        guard = 0;
        while (sorted_expected.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (100)
            @(posedge clk);
        if (error_count == 0 && sorted_expected.size() == 0)
            $display("lsd_decimal_radix_sort_tb: done, clean");
        else
            $display("lsd_decimal_radix_sort_tb: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
design/lsd_pkg.sv
design/lsd_ram.sv
design/lsd_div10.sv
design/lsd_decimal_radix_sort.sv
design/lsd_checker.sv
test/lsd_decimal_radix_sort_tb.sv
